FILE: rtl/mqs_pkg.sv
// ----------------------------------------------------------------------------
// mqs_pkg: shared types and constants of the multilevel scheduler
// Operation codes, status codes, payload structs and the engine state enum.
// ----------------------------------------------------------------------------
package mqs_pkg;

    localparam int KIND_W    = 2;
    localparam int TASK_W    = 8;
    localparam int LVL_W     = 3;
    localparam int RT_W      = 48;
    localparam int STATUS_W  = 2;
    localparam int QUOTA_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_REGS  = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_PICK   = 2'd2,
        KIND_SETRT  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_LEVEL = 2'd3
    } status_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TASK_W-1:0] task_id;
        logic [LVL_W-1:0]  level;
        logic [RT_W-1:0]   runtime;
    } in_item_t;

    typedef struct packed {
        logic              picked;
        logic [TASK_W-1:0] picked_id;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_LEVEL,
        ENG_SHIFT,
        ENG_DONE
    } eng_state_t;

    // Quota reset values for the first four levels
    function automatic logic [QUOTA_W-1:0] quota_reset(input int idx);
        unique case (idx)
            0: quota_reset = 4'd4;
            1: quota_reset = 4'd3;
            2: quota_reset = 4'd2;
            3: quota_reset = 4'd1;
            default: quota_reset = 4'd1;
        endcase
    endfunction

endpackage

FILE: rtl/mqs_front.sv
// ----------------------------------------------------------------------------
// mqs_front: input side of the scheduler
// Accepts transactions and holds them in a short queue.
// ----------------------------------------------------------------------------
module mqs_front #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  mqs_pkg::in_item_t in_item,
    output logic              q_valid,
    output mqs_pkg::in_item_t q_item,
    input  logic              q_take
);
    import mqs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    in_item_t         mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == (PW+1)'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_next  = do_push ? ((wr_reg == PW'(DEPTH-1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop ? ((rd_reg == PW'(DEPTH-1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store item payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end
endmodule

FILE: rtl/mqs_back.sv
// ----------------------------------------------------------------------------
// mqs_back: scheduling engine
// Walks the entry table one slot at a time to carry out add, remove,
// set runtime and pick, then places one result in a small output register.
// ----------------------------------------------------------------------------
module mqs_back #(
    parameter int ENTRIES_PER_LEVEL = 16,
    parameter int LEVELS            = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  mqs_pkg::in_item_t           q_item,
    output logic                        q_take,
    input  logic [mqs_pkg::QUOTA_W-1:0] quota [LEVELS],
    output logic                        empty,
    input  logic                        pop,
    output mqs_pkg::out_item_t          out_item
);
    import mqs_pkg::*;

    localparam int EW    = (ENTRIES_PER_LEVEL > 1) ? $clog2(ENTRIES_PER_LEVEL) : 1;
    localparam int LW    = $clog2(LEVELS);
    localparam int SLOTS = LEVELS * ENTRIES_PER_LEVEL;
    localparam int SW    = $clog2(SLOTS);
    localparam int OW    = $clog2(ENTRIES_PER_LEVEL + 1);

    // Slot memories: task, runtime and rank; valid bits in flip-flops
    logic [TASK_W-1:0] task_mem  [SLOTS];
    logic [RT_W-1:0]   rt_mem    [SLOTS];
    logic [OW-1:0]     order_mem [SLOTS];
    logic [SLOTS-1:0]  valid_reg;
    logic [QUOTA_W-1:0] count_reg [LEVELS];
    logic [TASK_W-1:0] rd_task_reg;
    logic [RT_W-1:0]   rd_rt_reg;
    logic [OW-1:0]     rd_ord_reg;

    eng_state_t        state_reg, state_next;
    in_item_t          cur_reg;
    logic [LW-1:0]     lvl_reg;
    logic [EW-1:0]     ent_reg;
    logic              rd_ok_reg;     // registered read data is for ent_reg
    logic              looped_reg;
    logic              found_reg;
    logic [EW-1:0]     best_reg;
    logic [RT_W-1:0]   best_rt_reg;
    logic [OW-1:0]     best_ord_reg;
    logic [TASK_W-1:0] best_task_reg;
    logic [OW-1:0]     fill_reg;
    logic              hasfree_reg;
    logic [EW-1:0]     free_reg;
    logic [OW-1:0]     rank_reg;
    out_item_t         res_reg;
    logic              res_valid_reg;

    logic [EW-1:0]     prev_ent;
    logic [SW-1:0]     lvl_base, rd_addr, prev_slot, free_slot, best_slot, rt_waddr;
    logic              last_ent, last_lvl;
    logic              q_level_full;
    logic              q_bad_level;
    status_t           init_status;
    logic              slot_hit;
    logic              wr_add, wr_setrt, wr_shift;

    assign empty    = !res_valid_reg;
    assign out_item = res_reg;
    assign q_take   = (state_reg == ENG_DONE);

    assign last_ent  = (ent_reg == EW'(ENTRIES_PER_LEVEL - 1));
    assign last_lvl  = (lvl_reg == LW'(LEVELS - 1));
    assign prev_ent  = ent_reg;
    assign lvl_base  = SW'(lvl_reg) * SW'(ENTRIES_PER_LEVEL);
    assign rd_addr   = lvl_base + SW'(ent_reg);
    assign prev_slot = lvl_base + SW'(prev_ent);
    assign free_slot = lvl_base + SW'(free_reg);
    assign best_slot = lvl_base + SW'(best_reg);
    assign q_level_full = (count_reg[lvl_reg] >= quota[lvl_reg]);
    assign q_bad_level  = (q_item.kind == KIND_ADD) && ({1'b0, q_item.level} >= 4'(LEVELS));

    // Table write strobes
    assign slot_hit = rd_ok_reg && valid_reg[prev_slot];
    assign wr_add   = (state_reg == ENG_LEVEL) && (cur_reg.kind == KIND_ADD) && hasfree_reg;
    assign wr_setrt = (state_reg == ENG_SCAN) && slot_hit && (cur_reg.kind == KIND_SETRT) &&
                      (rd_task_reg == cur_reg.task_id);
    assign wr_shift = (state_reg == ENG_SHIFT) && slot_hit && (rd_ord_reg > rank_reg);
    assign rt_waddr = wr_add ? free_slot : prev_slot;

    // Initial status of a new transaction
    always_comb
    begin
        if (q_bad_level)
            init_status = ST_BAD_LEVEL;
        else if (q_item.kind == KIND_SETRT || q_item.kind == KIND_REMOVE)
            init_status = ST_NOT_FOUND;
        else
            init_status = ST_OK;
    end

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_add)
        begin
            task_mem[free_slot] <= cur_reg.task_id;
        end
        if (wr_add || wr_setrt)
        begin
            rt_mem[rt_waddr] <= cur_reg.runtime;
        end
        if (wr_add)
        begin
            order_mem[free_slot] <= fill_reg;
        end
        else if (wr_shift)
        begin
            order_mem[prev_slot] <= rd_ord_reg - 1'b1;
        end
        rd_task_reg <= task_mem[rd_addr];
        rd_rt_reg   <= rt_mem[rd_addr];
        rd_ord_reg  <= order_mem[rd_addr];
    end

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE:
            begin
                if (q_valid && !res_valid_reg)
                    state_next = q_bad_level ? ENG_DONE : ENG_SCAN;
            end
            ENG_SCAN:  if (rd_ok_reg && last_ent) state_next = ENG_LEVEL;
            ENG_LEVEL:
            begin
                state_next = ENG_SCAN;
                unique case (kind_t'(cur_reg.kind))
                    KIND_ADD:    state_next = ENG_DONE;
                    KIND_SETRT:  if (last_lvl) state_next = ENG_DONE;
                    KIND_REMOVE:
                    begin
                        if (found_reg)
                            state_next = ENG_SHIFT;
                        else if (last_lvl)
                            state_next = ENG_DONE;
                    end
                    default:
                    begin
                        // Pick
                        if (q_level_full)
                        begin
                            if (last_lvl)
                                state_next = ENG_DONE;
                        end
                        else if (!found_reg)
                        begin
                            if (last_lvl && looped_reg)
                                state_next = ENG_DONE;
                        end
                        else
                            state_next = ENG_DONE;
                    end
                endcase
            end
            ENG_SHIFT: if (rd_ok_reg && last_ent) state_next = ENG_DONE;
            ENG_DONE:  state_next = ENG_IDLE;
            default:   state_next = ENG_IDLE;
        endcase
    end

    // Main datapath. Each slot is first addressed, then its registered read
    // data is examined (rd_ok_reg). A level is finished in ENG_LEVEL.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_IDLE;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
            lvl_reg       <= '0;
            ent_reg       <= '0;
            looped_reg    <= 1'b0;
            cur_reg       <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            best_rt_reg   <= '0;
            best_ord_reg  <= '0;
            best_task_reg <= '0;
            fill_reg      <= '0;
            hasfree_reg   <= 1'b0;
            free_reg      <= '0;
            rank_reg      <= '0;
            res_reg       <= '0;
            for (int l = 0; l < LEVELS; l++)
            begin
                count_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // Raise the result when done, drop it when popped
            if (state_reg == ENG_DONE)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ENG_IDLE:
                begin
                    if (q_valid && !res_valid_reg)
                    begin
                        cur_reg       <= q_item;
                        lvl_reg       <= (q_item.kind == KIND_ADD) ? LW'(q_item.level) : '0;
                        ent_reg       <= '0;
                        rd_ok_reg     <= 1'b0;
                        looped_reg    <= 1'b0;
                        found_reg     <= 1'b0;
                        fill_reg      <= '0;
                        hasfree_reg   <= 1'b0;
                        res_reg       <= '{picked: 1'b0, picked_id: '0, status: init_status};
                    end
                end
                ENG_SCAN:
                begin
                    // Issue next read; examine the slot read last cycle
                    if (!rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                    end
                    else
                    begin
                        if (!last_ent)
                        begin
                            ent_reg <= ent_reg + 1'b1;
                            rd_ok_reg <= 1'b0;
                        end
                        if (valid_reg[prev_slot])
                        begin
                            fill_reg <= fill_reg + 1'b1;
                            unique case (kind_t'(cur_reg.kind))
                                KIND_SETRT:
                                begin
                                    if (rd_task_reg == cur_reg.task_id)
                                    begin
                                        res_reg.status <= ST_OK;
                                    end
                                end
                                KIND_REMOVE:
                                begin
                                    if (rd_task_reg == cur_reg.task_id &&
                                        (!found_reg || rd_ord_reg < best_ord_reg))
                                    begin
                                        found_reg    <= 1'b1;
                                        best_reg     <= prev_ent;
                                        best_ord_reg <= rd_ord_reg;
                                    end
                                end
                                KIND_PICK:
                                begin
                                    if (!found_reg || rd_rt_reg < best_rt_reg ||
                                        (rd_rt_reg == best_rt_reg &&
                                         rd_ord_reg < best_ord_reg))
                                    begin
                                        found_reg     <= 1'b1;
                                        best_reg      <= prev_ent;
                                        best_rt_reg   <= rd_rt_reg;
                                        best_ord_reg  <= rd_ord_reg;
                                        best_task_reg <= rd_task_reg;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        else if (!hasfree_reg)
                        begin
                            hasfree_reg <= 1'b1;
                            free_reg    <= prev_ent;
                        end
                    end
                end
                ENG_LEVEL:
                begin
                    // Finish one level and decide where to go next
                    ent_reg   <= '0;
                    rd_ok_reg <= 1'b0;
                    fill_reg  <= '0;
                    found_reg <= 1'b0;
                    hasfree_reg <= 1'b0;
                    unique case (kind_t'(cur_reg.kind))
                        KIND_ADD:
                        begin
                            if (hasfree_reg)
                                valid_reg[free_slot] <= 1'b1;
                            else
                                res_reg.status <= ST_FULL;
                        end
                        KIND_SETRT:
                        begin
                            if (!last_lvl)
                                lvl_reg <= lvl_reg + 1'b1;
                        end
                        KIND_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                rank_reg <= best_ord_reg;
                                valid_reg[best_slot] <= 1'b0;
                                res_reg.status <= ST_OK;
                            end
                            else if (!last_lvl)
                                lvl_reg <= lvl_reg + 1'b1;
                        end
                        default:
                        begin
                            // Pick
                            if (q_level_full)
                            begin
                                if (!last_lvl)
                                    lvl_reg <= lvl_reg + 1'b1;
                            end
                            else if (!found_reg)
                            begin
                                if (!last_lvl)
                                begin
                                    count_reg[lvl_reg] <= '0;
                                    lvl_reg <= lvl_reg + 1'b1;
                                end
                                else if (!looped_reg)
                                begin
                                    for (int l = 0; l < LEVELS; l++)
                                        count_reg[l] <= '0;
                                    looped_reg <= 1'b1;
                                    lvl_reg    <= '0;
                                end
                            end
                            else
                            begin
                                res_reg.picked    <= 1'b1;
                                res_reg.picked_id <= best_task_reg;
                                if (last_lvl &&
                                    count_reg[lvl_reg] + 1'b1 >= quota[lvl_reg])
                                begin
                                    for (int l = 0; l < LEVELS; l++)
                                        count_reg[l] <= '0;
                                end
                                else if (count_reg[LEVELS-1] >= quota[LEVELS-1])
                                begin
                                    for (int l = 0; l < LEVELS; l++)
                                        count_reg[l] <= '0;
                                end
                                else
                                    count_reg[lvl_reg] <= count_reg[lvl_reg] + 1'b1;
                            end
                        end
                    endcase
                end
                ENG_SHIFT:
                begin
                    // Close the rank gap left by a removal, one slot per read
                    if (!rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                    end
                    else if (!last_ent)
                    begin
                        ent_reg   <= ent_reg + 1'b1;
                        rd_ok_reg <= 1'b0;
                    end
                end
                ENG_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

FILE: rtl/multilevel_quota_min_runtime_scheduler_unit.sv
// ----------------------------------------------------------------------------
// multilevel_quota_min_runtime_scheduler_unit: top level
// One transaction is handled at a time. The engine reads the table one slot
// at a time through a registered port, in passes over one level each, and
// each transaction has a start and a finish state. An add to an unknown level
// skips the table, an add makes one level pass, a set runtime passes every
// level, a remove passes levels until it finds the task and then makes one
// rank pass, and a pick may scan all levels twice when no task is found in
// the first round. A two-entry input queue accepts transactions while the
// engine works, and one result register holds the answer until popped; the
// next transaction starts only after that pop.
// ----------------------------------------------------------------------------
module multilevel_quota_min_runtime_scheduler_unit #(
    parameter int ENTRIES_PER_LEVEL = 16,
    parameter int LEVELS            = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  mqs_pkg::in_item_t             in_item,
    output logic                          empty,
    input  logic                          pop,
    output mqs_pkg::out_item_t            out_item,
    input  logic                          cfg_we,
    input  logic [mqs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mqs_pkg::QUOTA_W-1:0]   cfg_data
);
    import mqs_pkg::*;

    logic [QUOTA_W-1:0] quota_reg [LEVELS];
    logic               q_valid, q_take;
    in_item_t           q_item;

    // Quota registers; levels past the fourth keep a fixed quota of one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
                quota_reg[l] <= quota_reset(l);
        end
        else if (cfg_we)
        begin
            for (int l = 0; l < LEVELS && l < CFG_REGS; l++)
                if (cfg_index == CFG_IDX_W'(l))
                    quota_reg[l] <= cfg_data;
        end
    end

    mqs_front #(.DEPTH(2)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_take  (q_take)
    );

    mqs_back #(
        .ENTRIES_PER_LEVEL (ENTRIES_PER_LEVEL),
        .LEVELS            (LEVELS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_take   (q_take),
        .quota    (quota_reg),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );
endmodule

FILE: rtl/mqs_checker.sv
// ----------------------------------------------------------------------------
// mqs_checker: port-level checks of the scheduler
// Watches result fields and queue flags over time.
// ----------------------------------------------------------------------------
module mqs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input mqs_pkg::out_item_t out_item
);
    import mqs_pkg::*;

    // Hold a waiting result until it is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_item))
        else $error("result changed while waiting");

    // An answer with an error status never shows a picked task
    a_nopick: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.status != ST_OK |-> !out_item.picked)
        else $error("picked set with error status");

    // An unpicked answer carries identifier zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !out_item.picked |-> out_item.picked_id == '0)
        else $error("stray picked_id");
endmodule

bind multilevel_quota_min_runtime_scheduler_unit mqs_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the multilevel quota scheduler
// Drives add, remove, pick and set-runtime transactions through the queue
// ports. A directed table comes first, then random phases under several quota
// settings. A scoreboard predicts every result in order and compares fields.
// ----------------------------------------------------------------------------
module testbench;
    import mqs_pkg::*;

    localparam int NLEV      = 4;
    localparam int NENT      = 16;
    localparam int NSLOT     = NLEV * NENT;
    localparam int WDOG_MAX  = 6000;
    localparam int PHASE_LEN = 240;
    localparam int HOLD_LEN  = 400;

    typedef struct {
        in_item_t  it;
        bit        chk;
        out_item_t exp;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    in_item_t             in_item;
    logic                 empty;
    logic                 pop;
    out_item_t            out_item;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [QUOTA_W-1:0]   cfg_data;

    // scheduler mirror
    bit                 slot_valid [NSLOT];
    logic [TASK_W-1:0]  slot_task  [NSLOT];
    logic [RT_W-1:0]    slot_rt    [NSLOT];
    logic [3:0]         slot_rank  [NSLOT];
    logic [QUOTA_W-1:0] slice_cnt  [NLEV];
    logic [QUOTA_W-1:0] quota_reg  [NLEV];

    stim_row_t pending_q[$];
    out_item_t result_q[$];
    int        errors;
    int        burst_left;
    bit        hold_req;

    multilevel_quota_min_runtime_scheduler_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Compute the answer of one transaction and advance the mirror
    function automatic out_item_t schedule_step(input in_item_t it);
        out_item_t r;
        int        n, hit, best, l;
        logic [3:0] rank;
        bit        looped;
        r = '0;
        r.status = ST_OK;
        case (kind_t'(it.kind))
            KIND_ADD:
            begin
                if (it.level >= NLEV)
                    r.status = ST_BAD_LEVEL;
                else
                begin
                    n = 0;
                    for (int e = 0; e < NENT; e++)
                        if (slot_valid[it.level*NENT+e]) n++;
                    r.status = ST_FULL;
                    for (int e = 0; e < NENT; e++)
                    begin
                        if (!slot_valid[it.level*NENT+e])
                        begin
                            slot_valid[it.level*NENT+e] = 1'b1;
                            slot_task[it.level*NENT+e]  = it.task_id;
                            slot_rt[it.level*NENT+e]    = it.runtime;
                            slot_rank[it.level*NENT+e]  = n[3:0];
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            KIND_REMOVE:
            begin
                r.status = ST_NOT_FOUND;
                for (l = 0; l < NLEV && r.status == ST_NOT_FOUND; l++)
                begin
                    hit = -1;
                    for (int s = l*NENT; s < (l+1)*NENT; s++)
                        if (slot_valid[s] && slot_task[s] == it.task_id &&
                            (hit < 0 || slot_rank[s] < slot_rank[hit]))
                            hit = s;
                    if (hit >= 0)
                    begin
                        rank = slot_rank[hit];
                        slot_valid[hit] = 1'b0;
                        for (int s = l*NENT; s < (l+1)*NENT; s++)
                            if (slot_valid[s] && slot_rank[s] > rank)
                                slot_rank[s] = slot_rank[s] - 1'b1;
                        r.status = ST_OK;
                    end
                end
            end
            KIND_SETRT:
            begin
                r.status = ST_NOT_FOUND;
                for (int s = 0; s < NSLOT; s++)
                    if (slot_valid[s] && slot_task[s] == it.task_id)
                    begin
                        slot_rt[s] = it.runtime;
                        r.status = ST_OK;
                    end
            end
            default:
            begin
                looped = 1'b0;
                l = 0;
                while (l < NLEV)
                begin
                    if (slice_cnt[l] >= quota_reg[l])
                    begin
                        l++;
                        continue;
                    end
                    best = -1;
                    for (int s = l*NENT; s < (l+1)*NENT; s++)
                        if (slot_valid[s] && (best < 0 || slot_rt[s] < slot_rt[best] ||
                            (slot_rt[s] == slot_rt[best] && slot_rank[s] < slot_rank[best])))
                            best = s;
                    if (best < 0)
                    begin
                        if (l < NLEV - 1)
                        begin
                            slice_cnt[l] = '0;
                            l++;
                            continue;
                        end
                        if (looped) break;
                        foreach (slice_cnt[i]) slice_cnt[i] = '0;
                        looped = 1'b1;
                        l = 0;
                        continue;
                    end
                    slice_cnt[l] = slice_cnt[l] + 1'b1;
                    if (slice_cnt[NLEV-1] >= quota_reg[NLEV-1])
                        foreach (slice_cnt[i]) slice_cnt[i] = '0;
                    r.picked    = 1'b1;
                    r.picked_id = slot_task[best];
                    break;
                end
            end
        endcase
        return r;
    endfunction

    // Predict on input transactions, check on output transactions, watch for hangs
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        out_item_t exp;
        stim_row_t row;
        bit        moved;
        moved = 1'b0;
        if (rst_n && push && !full)
        begin
            moved = 1'b1;
            row = pending_q.pop_front();
            exp = schedule_step(row.it);
            result_q.push_back(row.chk ? row.exp : exp);
        end
        if (rst_n && pop && !empty)
        begin
            moved = 1'b1;
            if (result_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %p", $time, out_item);
            end
            else
            begin
                exp = result_q.pop_front();
                if (out_item.picked !== exp.picked || out_item.picked_id !== exp.picked_id ||
                    out_item.status !== exp.status)
                begin
                    errors++;
                    $display("%0t: mismatch expected %p actual %p", $time, exp, out_item);
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("%0t: watchdog expired", $time);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Drain results on a changing stall pattern, with an optional long hold-off
    initial
    begin
        int mode;
        pop = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 120))
            begin
                @(negedge clk);
                if (hold_req)
                begin
                    hold_req = 1'b0;
                    pop = 1'b0;
                    repeat (HOLD_LEN) @(negedge clk);
                end
                case (mode)
                    0: pop = 1'b1;
                    1: pop = 1'($urandom_range(0, 1));
                    default: pop = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one transaction, hold it until taken, then maybe open a gap
    task automatic send_item(input in_item_t it, input bit chk, input out_item_t exp);
        stim_row_t row;
        row.it = it;
        row.chk = chk;
        row.exp = exp;
        @(negedge clk);
        pending_q.push_back(row);
        in_item = it;
        push = 1'b1;
        do @(posedge clk); while (full);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            @(negedge clk);
            push = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        push = 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_quota(input int idx, input logic [QUOTA_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx[CFG_IDX_W-1:0];
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        quota_reg[idx] = val;
    endtask

    function automatic in_item_t make_item(input kind_t k, input int tid, input int lvl,
                                           input logic [RT_W-1:0] rt);
        in_item_t it;
        it.kind = k;
        it.task_id = tid[TASK_W-1:0];
        it.level = lvl[LVL_W-1:0];
        it.runtime = rt;
        return it;
    endfunction

    function automatic in_item_t random_item(input int add_w);
        in_item_t it;
        int       w;
        w = $urandom_range(0, 99);
        if (w < add_w) it.kind = KIND_ADD;
        else if (w < add_w + (100 - add_w) / 4) it.kind = KIND_REMOVE;
        else if (w < add_w + (100 - add_w) * 3 / 4) it.kind = KIND_PICK;
        else it.kind = KIND_SETRT;
        it.task_id = ($urandom_range(0, 9) == 0) ? TASK_W'($urandom_range(0, 255))
                                                 : TASK_W'($urandom_range(0, 23));
        it.level = ($urandom_range(0, 9) == 0) ? LVL_W'($urandom_range(4, 7))
                                               : LVL_W'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0: it.runtime = RT_W'($urandom_range(0, 7));
            1: it.runtime = RT_W'({$urandom, $urandom});
            2: it.runtime = '1;
            default: it.runtime = RT_W'($urandom_range(0, 1000));
        endcase
        return it;
    endfunction

    initial
    begin
        stim_row_t              table_rows[$];
        out_item_t              none;
        logic [QUOTA_W-1:0]     q_sets [6][NLEV];
        int                     add_w;

        errors = 0;
        hold_req = 1'b0;
        burst_left = 5;
        push = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        for (int i = 0; i < NSLOT; i++) slot_valid[i] = 1'b0;
        for (int i = 0; i < NLEV; i++)
        begin
            slice_cnt[i] = '0;
            quota_reg[i] = quota_reset(i);
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        none = '0;
        // directed table: typed answers where obvious, mirror elsewhere
        table_rows = '{
            '{make_item(KIND_PICK, 0, 0, 0), 1, '{1'b0, 8'd0, ST_OK}},
            '{make_item(KIND_REMOVE, 5, 0, 0), 1, '{1'b0, 8'd0, ST_NOT_FOUND}},
            '{make_item(KIND_SETRT, 5, 0, 1), 1, '{1'b0, 8'd0, ST_NOT_FOUND}},
            '{make_item(KIND_ADD, 255, 7, '1), 1, '{1'b0, 8'd0, ST_BAD_LEVEL}},
            '{make_item(KIND_ADD, 9, 4, 0), 1, '{1'b0, 8'd0, ST_BAD_LEVEL}},
            '{make_item(KIND_ADD, 0, 0, '1), 1, '{1'b0, 8'd0, ST_OK}},
            '{make_item(KIND_ADD, 1, 0, '1), 1, '{1'b0, 8'd0, ST_OK}},
            '{make_item(KIND_ADD, 2, 3, 0), 0, none},
            '{make_item(KIND_ADD, 2, 1, 0), 0, none},
            '{make_item(KIND_ADD, 3, 2, 5), 0, none},
            '{make_item(KIND_PICK, 0, 0, 0), 0, none},
            '{make_item(KIND_SETRT, 1, 0, 0), 0, none},
            '{make_item(KIND_PICK, 0, 0, 0), 0, none},
            '{make_item(KIND_PICK, 0, 0, 0), 0, none},
            '{make_item(KIND_PICK, 0, 0, 0), 0, none},
            '{make_item(KIND_PICK, 0, 0, 0), 0, none},
            '{make_item(KIND_PICK, 0, 0, 0), 0, none},
            '{make_item(KIND_PICK, 0, 0, 0), 0, none},
            '{make_item(KIND_REMOVE, 2, 0, 0), 0, none},
            '{make_item(KIND_REMOVE, 0, 0, 0), 0, none},
            '{make_item(KIND_ADD, 7, 0, 0), 0, none},
            '{make_item(KIND_PICK, 0, 0, 0), 0, none},
            '{make_item(KIND_SETRT, 2, 0, 48'h8000_0000_0000), 0, none},
            '{make_item(KIND_PICK, 0, 0, 0), 0, none},
            '{make_item(KIND_PICK, 0, 0, 0), 0, none}
        };
        foreach (table_rows[i])
            send_item(table_rows[i].it, table_rows[i].chk, table_rows[i].exp);

        // quota settings per random phase, extremes included
        q_sets = '{'{4'd15, 4'd15, 4'd15, 4'd15}, '{4'd0, 4'd0, 4'd0, 4'd0},
                   '{4'd1, 4'd1, 4'd1, 4'd1}, '{4'd0, 4'd2, 4'd0, 4'd15},
                   '{4'd3, 4'd0, 4'd5, 4'd0}, '{4'd4, 4'd3, 4'd2, 4'd1}};
        for (int p = 0; p < 6; p++)
        begin
            wait_idle();
            for (int i = 0; i < NLEV; i++)
                write_quota(i, (p == 5 && i == 0) ? 4'($urandom_range(0, 15)) : q_sets[p][i]);
            if (p == 2) hold_req = 1'b1;
            add_w = (p == 1 || p == 3) ? 60 : 30;
            repeat (PHASE_LEN)
                send_item(random_item(add_w), 1'b0, none);
        end

        // drain and settle
        @(negedge clk);
        push = 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
